[rtl/core/mbps_pkg.sv]
// package for the masked byte pattern search core
// word types, register indexes, widths and reset values; no dependencies

package mbps_pkg;

    localparam int ADDR_W        = 48;
    localparam int LEN_W         = 5;
    localparam int HIT_W         = 16;
    localparam int PATTERN_BYTES = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [PATTERN_BYTES-1:0] CARE_RESET  = 16'hFFFF;
    localparam logic [LEN_W-1:0]         LEN_RESET   = 5'd1;
    localparam logic [HIT_W-1:0]         LIMIT_RESET = 16'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_ADDRESS  = 3'd0,
        REG_PATTERN_LOW    = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_CARE_MASK      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_HIT_LIMIT      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } mbps_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] hit_address;
        logic              found;
        logic              done_res;
    } mbps_out_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  wdata;
    } mbps_cfg_wr_t;

    typedef struct packed {
        logic                          enable;
        logic [PATTERN_BYTES-1:0][7:0] pattern;
        logic [PATTERN_BYTES-1:0]      care;
        logic [LEN_W-1:0]              len;
        logic [HIT_W-1:0]              limit;
        logic [ADDR_W-1:0]             base;
    } mbps_cfg_t;

    typedef struct packed {
        logic              emit;
        logic              found;
        logic              done_res;
        logic [ADDR_W-1:0] hit_address;
    } mbps_result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pos;
        logic [HIT_W-1:0]  hits;
    } mbps_scan_status_t;

endpackage

[rtl/core/mbps_stream_if.sv]
// valid/ready channel with a typed payload
// used for the byte, hit and configuration channels; no dependencies

interface mbps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/mbps_cfg_regs.sv]
// configuration register file and derived scan settings
// depends on mbps_pkg

module mbps_cfg_regs #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     wr_data,
    output mbps_pkg::mbps_cfg_t                 cfg
);
    import mbps_pkg::*;

    logic [ADDR_W-1:0]        start_reg;
    logic [63:0]              pattern_low_reg;
    logic [63:0]              pattern_high_reg;
    logic [PATTERN_BYTES-1:0] care_reg;
    logic [LEN_W-1:0]         length_reg;
    logic [HIT_W-1:0]         limit_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [ADDR_W-1:0]        base_next;
    logic [LEN_W-1:0]         eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg        <= '0;
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_reg         <= CARE_RESET;
            length_reg       <= LEN_RESET;
            limit_reg        <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_START_ADDRESS:  start_reg        <= wr_data[ADDR_W-1:0];
                REG_PATTERN_LOW:    pattern_low_reg  <= wr_data;
                REG_PATTERN_HIGH:   pattern_high_reg <= wr_data;
                REG_CARE_MASK:      care_reg         <= wr_data[PATTERN_BYTES-1:0];
                REG_PATTERN_LENGTH: length_reg       <= wr_data[LEN_W-1:0];
                REG_HIT_LIMIT:      limit_reg        <= wr_data[HIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // lengths above the window depth use the full window
    assign eff_len = (length_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : length_reg;

    // match start = start - len + consumed = (start - len + 1) + position
    assign base_next = start_reg - ADDR_W'(eff_len) + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    always_comb
    begin
        cfg.enable  = (start_reg != '0);
        cfg.pattern = {pattern_high_reg, pattern_low_reg};
        cfg.care    = care_reg;
        cfg.len     = eff_len;
        cfg.limit   = (limit_reg == '0) ? HIT_W'(1) : limit_reg;
        cfg.base    = base_reg;
    end

endmodule

[rtl/core/mbps_match.sv]
// byte window, scan position and hit count with the parallel masked compare
// depends on mbps_pkg

module mbps_match #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  mbps_pkg::mbps_cfg_t           cfg,
    output mbps_pkg::mbps_result_t        result,
    output mbps_pkg::mbps_scan_status_t   status
);
    import mbps_pkg::*;

    logic [7:0]              window_reg [PATTERN_MAX];
    logic [7:0]              window_new [PATTERN_MAX];
    logic [ADDR_W-1:0]       pos_reg;
    logic [ADDR_W-1:0]       pos_next;
    logic [HIT_W-1:0]        hits_reg;
    logic [HIT_W-1:0]        hits_next;
    logic [ADDR_W-1:0]       consumed;
    logic [PATTERN_MAX-1:0]  byte_ok;
    logic                    match;
    logic [ADDR_W-1:0]       addr;

    // newest byte sits at index 0
    always_comb
    begin
        window_new[0] = data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            window_new[i] = window_reg[i-1];
        end
    end

    assign consumed = pos_reg + ADDR_W'(1);
    assign addr     = cfg.base + pos_reg;

    // pattern byte j lines up with window entry len-1-j
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        logic [7:0]       sel;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            idx = cfg.len - LEN_W'(j) - LEN_W'(1);
            sel = '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                if (idx == LEN_W'(k))
                begin
                    sel = window_new[k];
                end
            end
            byte_ok[j] = (LEN_W'(j) >= cfg.len) || !cfg.care[j]
                         || (sel == cfg.pattern[j]);
        end
    end

    assign match = cfg.enable && (cfg.len != '0)
                   && ((consumed[ADDR_W-1:LEN_W] != '0) || (consumed[LEN_W-1:0] >= cfg.len))
                   && (hits_reg < cfg.limit) && (&byte_ok);

    always_comb
    begin
        pos_next  = last_byte ? '0 : consumed;
        hits_next = last_byte ? '0 : (match ? hits_reg + HIT_W'(1) : hits_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hits_reg <= '0;
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            hits_reg <= hits_next;
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                window_reg[i] <= last_byte ? 8'h00 : window_new[i];
            end
        end
    end

    always_comb
    begin
        result.emit        = match || last_byte;
        result.found       = match;
        result.done_res    = last_byte;
        result.hit_address = match ? addr : '0;
        status.pos         = pos_reg;
        status.hits        = hits_reg;
    end

endmodule

[rtl/core/masked_byte_pattern_search_core.sv]
// top level of the masked byte pattern search core
// depends on mbps_pkg, mbps_stream_if, mbps_cfg_regs and mbps_match
//
//   channel      dir  word                               taken when
//   cfg          in   index, wdata                       cfg.valid (ready tied high)
//   byte_stream  in   data_byte, last_byte               valid && ready
//   hit_stream   out  hit_address, found, done_res       valid && ready
//
// one byte per cycle unless hit_stream stalls; each result passes the
// input register, then the compare and result register
// the window compare, position and hit count update all sit in one stage
// reset clears window, position, hits and valid bits, and resets the config
// a stalled result register holds the compare stage; byte_stream keeps taking
// a byte while the input register is free or moving

module masked_byte_pattern_search_core #(
    parameter int PATTERN_MAX = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mbps_stream_if.sink   cfg,
    mbps_stream_if.sink   byte_stream,
    mbps_stream_if.source hit_stream
);
    import mbps_pkg::*;

    mbps_cfg_t          scan_cfg;
    mbps_result_t       result;
    mbps_scan_status_t  status;

    logic               a_valid_reg;
    logic [7:0]         a_byte_reg;
    logic               a_last_reg;
    logic               advance;
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  hit_address_reg;
    logic               found_reg;
    logic               done_reg;
    logic               in_take;

    assign cfg.ready = 1'b1;

    mbps_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.payload.index),
        .wr_data  (cfg.payload.wdata),
        .cfg      (scan_cfg)
    );

    mbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (a_byte_reg),
        .last_byte (a_last_reg),
        .cfg       (scan_cfg),
        .result    (result),
        .status    (status)
    );

    assign advance           = a_valid_reg && (!out_valid_reg || hit_stream.ready);
    assign byte_stream.ready = !a_valid_reg || advance;
    assign in_take           = byte_stream.valid && byte_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            a_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_byte_reg <= byte_stream.payload.data_byte;
            a_last_reg <= byte_stream.payload.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || hit_stream.ready)
        begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            hit_address_reg <= result.hit_address;
            found_reg       <= result.found;
            done_reg        <= result.done_res;
        end
    end

    assign hit_stream.valid               = out_valid_reg;
    assign hit_stream.payload.hit_address = hit_address_reg;
    assign hit_stream.payload.found       = found_reg;
    assign hit_stream.payload.done_res    = done_reg;

    // a held result always reports a hit or the end of a region
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (found_reg || done_reg))
        else $error("empty result word held");

    // the last byte of a region leaves a cleared scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && a_last_reg) |=> (status.pos == '0 && status.hits == '0))
        else $error("scan not cleared after last byte");

    // scan state only moves when a byte is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(status.pos) && $stable(status.hits))
        else $error("scan state moved without a byte");

    // hits are only reported with a nonzero start address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> scan_cfg.enable)
        else $error("hit reported while disabled");

endmodule
